@@ sv/bgi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants, gamma tables and the microprogram for the
// brightness gamma interpolator. No dependencies.
package bgi_pkg;

    localparam int GammaRegs   = 21;
    localparam int GammaLevels = 9;
    localparam int StepW       = 3;
    localparam int IdxW        = 5;
    localparam int LvlW        = 4;

    localparam logic [7:0] ValMin    = 8'd10;
    localparam logic [7:0] ValMax    = 8'd250;
    localparam logic [7:0] LowLimit  = 8'd31;
    localparam logic [7:0] LowForce  = 8'd20;
    localparam logic [7:0] BankReg   = 8'h39;
    localparam logic [7:0] BankByte0 = 8'h43;
    localparam logic [7:0] BankByte1 = 8'h34;
    localparam logic [4:0] LevelStep = 5'd30;

    // Reciprocals of 30: 137/4096 for level split, 2185/65536 for the blend
    localparam logic [15:0] LevelRecip = 16'd137;
    localparam logic [23:0] DivRecip   = 24'd2185;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(GammaRegs - 1);

    localparam logic [StepW-1:0] StepIdle  = 3'd0;
    localparam logic [StepW-1:0] StepSplit = 3'd1;
    localparam logic [StepW-1:0] StepFrac  = 3'd2;
    localparam logic [StepW-1:0] StepLoad  = 3'd3;
    localparam logic [StepW-1:0] StepMac   = 3'd4;
    localparam logic [StepW-1:0] StepEmit  = 3'd5;
    localparam logic [StepW-1:0] StepBank  = 3'd6;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_SPLIT,
        ACT_FRAC,
        ACT_LOAD,
        ACT_MAC,
        ACT_EMIT,
        ACT_BANK
    } act_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_ALWAYS,
        BR_MORE
    } br_t;

    typedef struct packed {
        act_t             act;
        cond_t            hold;
        br_t              br;
        logic [StepW-1:0] target;
    } uword_t;

    typedef struct packed {
        act_t act;
        logic in_ready;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
        logic idx_last;
    } stat_t;

    localparam logic [7:0] GAMMA_ADDR [GammaRegs] = '{
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
        8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [7:0] GAMMA_ROM [GammaLevels][GammaRegs] = '{
        '{8'h00,8'h3f,8'h40,8'h39,8'h32,8'h2e,8'h0c, 8'h00,8'h00,8'h00,8'h00,
          8'h26,8'h2d,8'h0b, 8'h00,8'h3f,8'h40,8'h38,8'h31,8'h2d,8'h12},
        '{8'h00,8'h3f,8'h3e,8'h2e,8'h2d,8'h28,8'h21, 8'h00,8'h00,8'h00,8'h21,
          8'h2a,8'h28,8'h20, 8'h00,8'h3f,8'h3e,8'h2d,8'h2b,8'h26,8'h2d},
        '{8'h00,8'h3f,8'h35,8'h2c,8'h2b,8'h26,8'h29, 8'h00,8'h00,8'h00,8'h25,
          8'h29,8'h26,8'h28, 8'h00,8'h3f,8'h34,8'h2b,8'h2a,8'h23,8'h37},
        '{8'h00,8'h3f,8'h30,8'h2a,8'h2b,8'h24,8'h2f, 8'h00,8'h00,8'h00,8'h25,
          8'h29,8'h24,8'h2e, 8'h00,8'h3f,8'h2f,8'h29,8'h29,8'h21,8'h3f},
        '{8'h00,8'h3f,8'h2e,8'h29,8'h2a,8'h23,8'h34, 8'h00,8'h00,8'h0a,8'h25,
          8'h28,8'h23,8'h33, 8'h00,8'h3f,8'h2d,8'h28,8'h27,8'h20,8'h46},
        '{8'h00,8'h3f,8'h2b,8'h29,8'h28,8'h23,8'h38, 8'h00,8'h00,8'h0b,8'h25,
          8'h27,8'h23,8'h37, 8'h00,8'h3f,8'h29,8'h28,8'h25,8'h20,8'h4b},
        '{8'h00,8'h3f,8'h29,8'h29,8'h27,8'h22,8'h3c, 8'h00,8'h00,8'h10,8'h26,
          8'h26,8'h22,8'h3b, 8'h00,8'h3f,8'h28,8'h28,8'h24,8'h1f,8'h50},
        '{8'h00,8'h3f,8'h28,8'h28,8'h28,8'h20,8'h40, 8'h00,8'h00,8'h11,8'h25,
          8'h27,8'h20,8'h3f, 8'h00,8'h3f,8'h27,8'h26,8'h26,8'h1c,8'h56},
        '{8'h00,8'h3f,8'h2a,8'h27,8'h27,8'h1f,8'h44, 8'h00,8'h00,8'h17,8'h24,
          8'h26,8'h1f,8'h43, 8'h00,8'h3f,8'h2a,8'h25,8'h24,8'h1b,8'h5c}
    };

    // Level one past the top reads as zero; it is only ever weighted by zero
    function automatic logic [7:0] rom_byte(input logic [LvlW-1:0] lvl,
                                            input logic [IdxW-1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (int'(lvl) < GammaLevels && int'(idx) < GammaRegs)
        begin
            res = GAMMA_ROM[lvl][idx];
        end
        return res;
    endfunction

    function automatic logic [7:0] addr_byte(input logic [IdxW-1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (int'(idx) < GammaRegs)
        begin
            res = GAMMA_ADDR[idx];
        end
        return res;
    endfunction

    // Microprogram: one control word per step
    function automatic uword_t ucode(input logic [StepW-1:0] step);
        uword_t w;
        case (step)
            StepIdle:  w = '{ACT_CAPTURE, COND_IN,   BR_NONE,   StepIdle};
            StepSplit: w = '{ACT_SPLIT,   COND_NONE, BR_NONE,   StepIdle};
            StepFrac:  w = '{ACT_FRAC,    COND_NONE, BR_NONE,   StepIdle};
            StepLoad:  w = '{ACT_LOAD,    COND_NONE, BR_NONE,   StepIdle};
            StepMac:   w = '{ACT_MAC,     COND_NONE, BR_NONE,   StepIdle};
            StepEmit:  w = '{ACT_EMIT,    COND_OUT,  BR_MORE,   StepLoad};
            StepBank:  w = '{ACT_BANK,    COND_OUT,  BR_ALWAYS, StepIdle};
            default:   w = '{ACT_NONE,    COND_NONE, BR_ALWAYS, StepIdle};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ sv/bgi_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Step counter and microprogram fetch for the gamma interpolator.
// Depends on bgi_pkg.
module bgi_sequencer
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire bgi_pkg::stat_t stat,
    output bgi_pkg::ctrl_t     ctrl
);

    logic [bgi_pkg::StepW-1:0] step_reg;
    logic [bgi_pkg::StepW-1:0] step_next;
    bgi_pkg::uword_t           uword;
    logic                      go;

    always_comb
    begin
        uword = bgi_pkg::ucode(step_reg);
        case (uword.hold)
            bgi_pkg::COND_NONE: go = 1'b1;
            bgi_pkg::COND_IN:   go = in_valid;
            bgi_pkg::COND_OUT:  go = stat.out_free;
            default:            go = 1'b1;
        endcase

        // Hold on an unmet condition, otherwise branch or advance
        if (!go)
        begin
            step_next = step_reg;
        end
        else if (uword.br == bgi_pkg::BR_ALWAYS ||
                 (uword.br == bgi_pkg::BR_MORE && !stat.idx_last))
        begin
            step_next = uword.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end

        ctrl.act      = go ? uword.act : bgi_pkg::ACT_NONE;
        ctrl.in_ready = (uword.hold == bgi_pkg::COND_IN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bgi_pkg::StepIdle;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == bgi_pkg::ACT_EMIT || ctrl.act == bgi_pkg::ACT_BANK) |-> stat.out_free)
        else $error("write issued into a full output register");

    a_capture_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == bgi_pkg::ACT_CAPTURE) |-> (ctrl.in_ready && in_valid))
        else $error("capture without an input transaction");

    a_bank_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == bgi_pkg::ACT_BANK) |=> (step_reg == bgi_pkg::StepIdle))
        else $error("sequencer did not return to idle after bank write");

endmodule
`default_nettype wire

@@ sv/bgi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Datapath: conditioning, level split, table read, blend, divide by 30
// and the output register. Depends on bgi_pkg.
module bgi_datapath
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bgi_pkg::ctrl_t ctrl,
    input  wire logic [7:0]     in_data,
    output bgi_pkg::stat_t      stat,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_addr,
    output logic [7:0]          out_value,
    output logic                out_last
);

    logic [7:0]                x_reg,      x_next;
    logic [bgi_pkg::LvlW-1:0]  level_reg,  level_next;
    logic [4:0]                frac_reg,   frac_next;
    logic [bgi_pkg::IdxW-1:0]  idx_reg,    idx_next;
    logic [7:0]                a_reg,      a_next;
    logic [7:0]                b_reg,      b_next;
    logic [11:0]               y_reg,      y_next;
    logic                      toggle_reg, toggle_next;
    logic                      valid_reg,  valid_next;
    logic [7:0]                addr_reg,   addr_next;
    logic [7:0]                value_reg,  value_next;
    logic                      last_reg,   last_next;

    logic [7:0]  cond_v;
    logic [15:0] split_prod;
    logic [12:0] mac_sum;
    logic [23:0] div_prod;
    logic        out_free;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        // Clamp, round down to even, force the low end
        cond_v = in_data;
        if (cond_v < bgi_pkg::ValMin)
        begin
            cond_v = bgi_pkg::ValMin;
        end
        if (cond_v > bgi_pkg::ValMax)
        begin
            cond_v = bgi_pkg::ValMax;
        end
        cond_v[0] = 1'b0;
        if (cond_v < bgi_pkg::LowLimit)
        begin
            cond_v = bgi_pkg::LowForce;
        end

        split_prod = 16'(x_reg) * bgi_pkg::LevelRecip;
        mac_sum    = 13'(a_reg) * 13'(bgi_pkg::LevelStep - frac_reg)
                   + 13'(b_reg) * 13'(frac_reg);
        div_prod   = 24'(y_reg) * bgi_pkg::DivRecip;

        x_next      = x_reg;
        level_next  = level_reg;
        frac_next   = frac_reg;
        idx_next    = idx_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        y_next      = y_reg;
        toggle_next = toggle_reg;
        valid_next  = out_ready ? 1'b0 : valid_reg;
        addr_next   = addr_reg;
        value_next  = value_reg;
        last_next   = last_reg;

        case (ctrl.act)
            bgi_pkg::ACT_CAPTURE:
            begin
                x_next = cond_v - bgi_pkg::ValMin;
            end
            bgi_pkg::ACT_SPLIT:
            begin
                level_next = split_prod[15:12];
            end
            bgi_pkg::ACT_FRAC:
            begin
                frac_next = 5'(x_reg - 8'({4'b0, level_reg} * 8'(bgi_pkg::LevelStep)));
                idx_next  = '0;
            end
            bgi_pkg::ACT_LOAD:
            begin
                a_next = bgi_pkg::rom_byte(level_reg, idx_reg);
                b_next = bgi_pkg::rom_byte(level_reg + 1'b1, idx_reg);
            end
            bgi_pkg::ACT_MAC:
            begin
                y_next = 12'(mac_sum);
            end
            bgi_pkg::ACT_EMIT:
            begin
                valid_next = 1'b1;
                addr_next  = bgi_pkg::addr_byte(idx_reg);
                value_next = div_prod[23:16];
                last_next  = 1'b0;
                idx_next   = idx_reg + 1'b1;
            end
            bgi_pkg::ACT_BANK:
            begin
                valid_next  = 1'b1;
                addr_next   = bgi_pkg::BankReg;
                value_next  = toggle_reg ? bgi_pkg::BankByte1 : bgi_pkg::BankByte0;
                last_next   = 1'b1;
                toggle_next = !toggle_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            toggle_reg <= toggle_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        level_reg <= level_next;
        frac_reg  <= frac_next;
        idx_reg   <= idx_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        y_reg     <= y_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign stat.out_free = out_free;
    assign stat.idx_last = (idx_reg == bgi_pkg::LastIdx);
    assign out_valid     = valid_reg;
    assign out_addr      = addr_reg;
    assign out_value     = value_reg;
    assign out_last      = last_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == bgi_pkg::ACT_FRAC) |=>
        (int'(level_reg) < bgi_pkg::GammaLevels) &&
        (int'(frac_reg) < 30) &&
        (int'(level_reg) != bgi_pkg::GammaLevels - 1 || frac_reg == 5'd0))
        else $error("level split out of range");

    a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == bgi_pkg::ACT_BANK) |=> (toggle_reg != $past(toggle_reg)))
        else $error("bank toggle did not flip");

    a_last_is_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (addr_reg == bgi_pkg::BankReg))
        else $error("final write not addressed to the bank register");

endmodule
`default_nettype wire

@@ sv/brightness_gamma_interpolator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the brightness gamma interpolator: microcoded sequencer
// driving the interpolation datapath. Depends on bgi_pkg, bgi_sequencer,
// bgi_datapath.
//
// Usage:
//   Slave channel: one transaction carries a brightness request (any 8-bit
//   value). Master channel: 22 transactions follow, 21 gamma register
//   writes (0x40..0x46, 0x50..0x56, 0x60..0x66) then one bank-select write
//   to 0x39 carrying 0x43 or 0x34 in turn, marked by tlast.
//   Timing: the sequencer spends one step on capture, two on splitting the
//   request into level and fraction, then three steps per gamma write
//   (table read, blend, divide and issue) and one for the bank write.
//   Without back-pressure the three-step loop per register sets how long a
//   request takes, and s_axis_tready rises again the cycle after the bank
//   write is issued.
//   Back-pressure: a full output register that is not taken holds the
//   sequencer at its issue step; nothing is dropped.
//   Reset: asynchronous, active low; returns the sequencer to idle, empties
//   the output register and clears the bank toggle to the 0x43 byte.
module brightness_gamma_interpolator_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] brightness
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] reg_address, [15:8] reg_value
    output logic             m_axis_tlast    // last_write
);

    bgi_pkg::ctrl_t ctrl;
    bgi_pkg::stat_t stat;
    logic [7:0]     out_addr;
    logic [7:0]     out_value;

    // Fetch control words and advance the step counter
    bgi_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Execute each step's action and hold the outgoing transaction
    bgi_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_data   (s_axis_tdata),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_addr  (out_addr),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tdata  = {out_value, out_addr};

endmodule
`default_nettype wire

@@ bench/bgi_write_checker.sv @@
`timescale 1ns / 1ps
// Checker for the brightness gamma interpolator: watches both stream channels,
// predicts the panel writes each brightness request causes and compares them.
// Self-contained; no package or RTL dependencies.
module bgi_write_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] brightness
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [7:0] reg_address, [15:8] reg_value
    input  wire logic        m_axis_tlast,   // last_write
    output int               fail_count,
    output int               outstanding
);

    localparam int GammaRegs   = 21;
    localparam int GammaLevels = 9;
    localparam int LevelStep   = 30;
    localparam int ValMin      = 10;
    localparam int ValMax      = 250;
    localparam int LowLimit    = 31;
    localparam int LowForce    = 20;
    localparam int RegsPerBank = 7;
    localparam int ReportLimit = 10;

    localparam logic [7:0] FirstGammaReg = 8'h40;
    localparam logic [7:0] BankStride    = 8'h10;
    localparam logic [7:0] BankReg       = 8'h39;
    localparam logic [7:0] BankByte0     = 8'h43;
    localparam logic [7:0] BankByte1     = 8'h34;

    localparam logic [7:0] GAMMA_TABLE [GammaLevels][GammaRegs] = '{
        '{8'h00,8'h3f,8'h40,8'h39,8'h32,8'h2e,8'h0c, 8'h00,8'h00,8'h00,8'h00,
          8'h26,8'h2d,8'h0b, 8'h00,8'h3f,8'h40,8'h38,8'h31,8'h2d,8'h12},
        '{8'h00,8'h3f,8'h3e,8'h2e,8'h2d,8'h28,8'h21, 8'h00,8'h00,8'h00,8'h21,
          8'h2a,8'h28,8'h20, 8'h00,8'h3f,8'h3e,8'h2d,8'h2b,8'h26,8'h2d},
        '{8'h00,8'h3f,8'h35,8'h2c,8'h2b,8'h26,8'h29, 8'h00,8'h00,8'h00,8'h25,
          8'h29,8'h26,8'h28, 8'h00,8'h3f,8'h34,8'h2b,8'h2a,8'h23,8'h37},
        '{8'h00,8'h3f,8'h30,8'h2a,8'h2b,8'h24,8'h2f, 8'h00,8'h00,8'h00,8'h25,
          8'h29,8'h24,8'h2e, 8'h00,8'h3f,8'h2f,8'h29,8'h29,8'h21,8'h3f},
        '{8'h00,8'h3f,8'h2e,8'h29,8'h2a,8'h23,8'h34, 8'h00,8'h00,8'h0a,8'h25,
          8'h28,8'h23,8'h33, 8'h00,8'h3f,8'h2d,8'h28,8'h27,8'h20,8'h46},
        '{8'h00,8'h3f,8'h2b,8'h29,8'h28,8'h23,8'h38, 8'h00,8'h00,8'h0b,8'h25,
          8'h27,8'h23,8'h37, 8'h00,8'h3f,8'h29,8'h28,8'h25,8'h20,8'h4b},
        '{8'h00,8'h3f,8'h29,8'h29,8'h27,8'h22,8'h3c, 8'h00,8'h00,8'h10,8'h26,
          8'h26,8'h22,8'h3b, 8'h00,8'h3f,8'h28,8'h28,8'h24,8'h1f,8'h50},
        '{8'h00,8'h3f,8'h28,8'h28,8'h28,8'h20,8'h40, 8'h00,8'h00,8'h11,8'h25,
          8'h27,8'h20,8'h3f, 8'h00,8'h3f,8'h27,8'h26,8'h26,8'h1c,8'h56},
        '{8'h00,8'h3f,8'h2a,8'h27,8'h27,8'h1f,8'h44, 8'h00,8'h00,8'h17,8'h24,
          8'h26,8'h1f,8'h43, 8'h00,8'h3f,8'h2a,8'h25,8'h24,8'h1b,8'h5c}
    };

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] value;
        logic       last;
    } panel_write_t;

    panel_write_t panel_write_q [$];
    logic         bank_sel;
    int           reported;

    // Clamp, round down to even, force the dim end to a single level
    function automatic int condition_brightness(input logic [7:0] req);
        int v;
        v = int'(req);
        if (v < ValMin)
        begin
            v = ValMin;
        end
        if (v > ValMax)
        begin
            v = ValMax;
        end
        v = v - (v % 2);
        if (v < LowLimit)
        begin
            v = LowForce;
        end
        return v;
    endfunction

    function automatic void queue_panel_writes(input logic [7:0] req, input logic sel);
        int           v;
        int           lvl;
        int           frac;
        int           lo;
        int           hi;
        int           blend;
        panel_write_t w;
        v    = condition_brightness(req);
        lvl  = (v - ValMin) / LevelStep;
        frac = (v - ValMin) % LevelStep;
        if (lvl >= GammaLevels - 1)
        begin
            lvl  = GammaLevels - 1;
            frac = 0;
        end
        for (int i = 0; i < GammaRegs; i++)
        begin
            lo = int'(GAMMA_TABLE[lvl][i]);
            if (frac == 0)
            begin
                blend = lo;
            end
            else
            begin
                hi    = int'(GAMMA_TABLE[lvl + 1][i]);
                blend = (lo * (LevelStep - frac) + hi * frac) / LevelStep;
            end
            w.addr  = FirstGammaReg + BankStride * 8'(i / RegsPerBank) + 8'(i % RegsPerBank);
            w.value = 8'(blend);
            w.last  = 1'b0;
            panel_write_q.push_back(w);
        end
        w.addr  = BankReg;
        w.value = sel ? BankByte1 : BankByte0;
        w.last  = 1'b1;
        panel_write_q.push_back(w);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_writes
        panel_write_t want;
        if (!rst_n)
        begin
            bank_sel   <= 1'b0;
            panel_write_q.delete();
            fail_count  = 0;
            reported    = 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare before queuing, so a request taken in the same cycle stays behind
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (panel_write_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (reported < ReportLimit)
                    begin
                        reported = reported + 1;
                        $display("%0t: unexpected write addr=%h value=%h last=%b", $realtime,
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
                    end
                end
                else
                begin
                    want = panel_write_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.addr || m_axis_tdata[15:8] !== want.value
                        || m_axis_tlast !== want.last)
                    begin
                        fail_count = fail_count + 1;
                        if (reported < ReportLimit)
                        begin
                            reported = reported + 1;
                            $display("%0t: write mismatch: expected addr=%h value=%h last=%b,",
                                     $realtime, want.addr, want.value, want.last);
                            $display("    got addr=%h value=%h last=%b",
                                     m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                queue_panel_writes(s_axis_tdata, bank_sel);
                bank_sel <= ~bank_sel;
            end
            outstanding <= panel_write_q.size();
        end
    end

endmodule

@@ bench/tb_brightness_gamma_interpolator_unit.sv @@
`timescale 1ns / 1ps
// Top-level testbench for brightness_gamma_interpolator_unit: drives brightness
// requests, stalls the write channel and gives the verdict. Needs the RTL and
// bgi_write_checker.
module tb_brightness_gamma_interpolator_unit;

    // Ample headroom for the ~110 requests in total, even with heavy stalls on
    // both sides.
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 32;
    localparam int PhaseItems  = 28;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] brightness
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] reg_address, [15:8] reg_value
    logic        m_axis_tlast;            // last_write

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int send_gap_pct = 0;   // chance per cycle that the request side holds off
    int recv_gap_pct = 0;   // chance per cycle that the write side stalls

    // Corner requests: both clamps, the low-force window and its edge, odd values
    // that round down, level boundaries, the largest fractions and the top level.
    logic [7:0] corner_req [25] = '{
        8'd0,   8'd255, 8'd1,   8'd9,   8'd10,  8'd11,  8'd30,  8'd31,  8'd32,
        8'd33,  8'd38,  8'd39,  8'd40,  8'd41,  8'd70,  8'd85,  8'd128, 8'd170,
        8'd219, 8'd238, 8'd248, 8'd249, 8'd250, 8'd251, 8'd254
    };

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    brightness_gamma_interpolator_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bgi_write_checker u_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Stall the write channel at random, one decision per cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("** brightness_gamma_interpolator_unit: FAILED **");
            $finish;
        end
    end

    // Present one request and hold it until the transaction completes. Lower
    // tvalid only inside an idle stretch so back-to-back requests keep it high.
    task automatic send_brightness(input logic [7:0] req);
        logic taken;
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        // Sample tready at the falling edge, where it is settled
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Drop tvalid and wait for every predicted write to drain
    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Bias a share of requests towards the clamp and low-force regions
    function automatic logic [7:0] pick_brightness();
        logic [7:0] req;
        case ($urandom_range(0, 3))
            0:       req = 8'($urandom_range(0, 40));
            1:       req = 8'($urandom_range(230, 255));
            default: req = 8'($urandom_range(0, 255));
        endcase
        return req;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: lazy sender, busy receiver
        send_gap_pct = 29;
        recv_gap_pct = 69;
        foreach (corner_req[i])
        begin
            send_brightness(corner_req[i]);
        end
        // Hold off until the write queue is empty before going random
        drain_writes();
        repeat (PhaseItems) send_brightness(pick_brightness());

        // Phase two: swap the idling between the sides
        send_gap_pct = 69;
        recv_gap_pct = 29;
        repeat (PhaseItems) send_brightness(pick_brightness());

        // Phase three: full rate on both sides
        drain_writes();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        repeat (PhaseItems) send_brightness(pick_brightness());

        drain_writes();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("** brightness_gamma_interpolator_unit: PASSED **");
        end
        else
        begin
            $display("** brightness_gamma_interpolator_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bgi_pkg.sv
sv/bgi_sequencer.sv
sv/bgi_datapath.sv
sv/brightness_gamma_interpolator_unit.sv
bench/bgi_write_checker.sv
bench/tb_brightness_gamma_interpolator_unit.sv
